// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen at a rising clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/esutc_pkg.sv =====
// constants and month table for the epoch seconds to utc date converter
`timescale 1ns / 1ps
`default_nettype none

package esutc_pkg;

  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [5:0]  SecsPerMin = 6'd60;
  localparam logic [10:0] BaseYear   = 11'd1970;
  localparam logic [8:0]  DaysCommon = 9'd365;
  localparam logic [8:0]  DaysLeap   = 9'd366;
  localparam logic [3:0]  LastMonth  = 4'd11;

  // ceil(2^34 / 675): seconds / 128 times this, shifted down 34, gives the day count
  localparam logic [24:0] DayRecip   = 25'd25451659;
  // ceil(2^19 / 15): value / 4 times this, shifted down 19, gives value / 60
  localparam logic [15:0] MinRecip   = 16'd34953;

  // month length, months numbered from zero
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/epoch_seconds_to_utc_date.sv =====
// top level: unix epoch seconds to gregorian utc date and time
//
// channel   direction  handshake                  payload
// input     in         in_valid_i / in_ready_o    epoch_seconds_i
// output    out        out_valid_o / out_ready_i  year, month, day, hour, minute, second, leap
//
// a transaction runs through the day count, time of day, minutes of day, second,
// hour and minute states of reciprocal multiply and remainder work, then the
// year walk that removes whole years, the month walk and the finish state, with
// the shared multiplier and subtractor doing the arithmetic; the next transaction
// is taken only once the result is loaded into the output register
// reset clears the sequencer and the output valid; no clearing pass
// the result sits in an output register, so a new transaction is taken while
// the previous result still waits on out_ready_i
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module epoch_seconds_to_utc_date
  import esutc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [30:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [10:0]      year_o,
  output logic [3:0]       month_number_o,
  output logic [4:0]       day_of_month_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic             leap_year_o
);

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDivDay = 4'd1;  // day count by reciprocal multiply
  localparam logic [3:0] StTod    = 4'd2;  // time of day = seconds - days * 86400
  localparam logic [3:0] StDivMin = 4'd3;  // minutes of day = time of day / 60
  localparam logic [3:0] StSec    = 4'd4;  // second = time of day - minutes * 60
  localparam logic [3:0] StDivHr  = 4'd5;  // hour = minutes of day / 60
  localparam logic [3:0] StMin    = 4'd6;  // minute = minutes of day - hour * 60
  localparam logic [3:0] StYear   = 4'd7;  // remove whole years
  localparam logic [3:0] StMonth  = 4'd8;  // walk month lengths
  localparam logic [3:0] StDone   = 4'd9;  // hand result to output register

  logic [3:0]  state_q, state_d;
  logic [30:0] num_q, num_d;    // seconds, then minutes of day, then hour
  logic [16:0] rem_q, rem_d;    // time of day, then hour, then minute
  logic [14:0] days_q, days_d;
  logic [5:0]  sec_q, sec_d;
  logic [10:0] year_q, year_d;
  logic [3:0]  mon_q, mon_d;
  logic        leap_q, leap_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [10:0] year_out_q;
  logic [3:0]  month_out_q;
  logic [4:0]  day_out_q;
  logic [4:0]  hour_out_q;
  logic [5:0]  minute_out_q;
  logic [5:0]  second_out_q;
  logic        leap_out_q;
  logic        load_out;

  // shared multiplier and shared subtract and compare unit
  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;
  logic [17:0] op_a, op_b;
  logic [18:0] diff;
  logic        fits;
  logic        leap_now;
  logic [8:0]  year_len;

  // within 1970..2038 the 4/100/400 rule reduces to divisibility by four
  assign leap_now = (year_q[1:0] == 2'b00);
  assign year_len = leap_now ? DaysLeap : DaysCommon;

  always_comb begin
    case (state_q)
      StDivDay:        mul_a = {1'b0, num_q[30:7]};
      StTod:           mul_a = {10'd0, days_q};
      StDivMin:        mul_a = {10'd0, rem_q[16:2]};
      StSec:           mul_a = {14'd0, num_q[10:0]};
      StDivHr:         mul_a = {16'd0, num_q[10:2]};
      StMin:           mul_a = {20'd0, rem_q[4:0]};
      default:         mul_a = '0;
    endcase
    case (state_q)
      StDivDay:        mul_b = DayRecip;
      StTod:           mul_b = {8'd0, SecsPerDay};
      StDivMin, StDivHr: mul_b = {9'd0, MinRecip};
      StSec, StMin:    mul_b = {19'd0, SecsPerMin};
      default:         mul_b = '0;
    endcase
  end

  assign mul_p = {25'd0, mul_a} * {25'd0, mul_b};

  always_comb begin
    case (state_q)
      StTod:           op_a = {1'b0, num_q[16:0]};
      StSec:           op_a = {1'b0, rem_q};
      StMin:           op_a = {7'd0, num_q[10:0]};
      StYear, StMonth: op_a = {3'b000, days_q};
      default:         op_a = '0;
    endcase
    case (state_q)
      StTod, StSec, StMin: op_b = {1'b0, mul_p[16:0]};
      StYear:            op_b = {9'd0, year_len};
      StMonth:           op_b = {13'd0, month_len(mon_q, leap_q)};
      default:           op_b = '0;
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign fits = ~diff[18];

  assign in_ready_o = (state_q == StIdle);
  assign load_out   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    days_d  = days_q;
    sec_d   = sec_q;
    year_d  = year_q;
    mon_d   = mon_q;
    leap_d  = leap_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          num_d   = epoch_seconds_i;
          state_d = StDivDay;
        end
      end
      StDivDay: begin
        days_d  = mul_p[48:34];
        state_d = StTod;
      end
      StTod: begin
        // remainder is below 86400, so the low 17 bits are exact
        rem_d   = diff[16:0];
        state_d = StDivMin;
      end
      StDivMin: begin
        num_d   = {20'd0, mul_p[29:19]};
        state_d = StSec;
      end
      StSec: begin
        sec_d   = diff[5:0];
        state_d = StDivHr;
      end
      StDivHr: begin
        rem_d   = {12'd0, mul_p[23:19]};
        state_d = StMin;
      end
      StMin: begin
        // hour moves to num_q, minute to rem_q
        num_d   = {26'd0, rem_q[4:0]};
        rem_d   = {11'd0, diff[5:0]};
        year_d  = BaseYear;
        state_d = StYear;
      end
      StYear: begin
        if (fits) begin
          days_d = diff[14:0];
          year_d = year_q + 11'd1;
        end else begin
          leap_d  = leap_now;
          mon_d   = '0;
          state_d = StMonth;
        end
      end
      StMonth: begin
        if (mon_q == LastMonth || !fits) begin
          state_d = StDone;
        end else begin
          days_d = diff[14:0];
          mon_d  = mon_q + 4'd1;
        end
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    days_q <= days_d;
    sec_q  <= sec_d;
    year_q <= year_d;
    mon_q  <= mon_d;
    leap_q <= leap_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      year_out_q   <= year_q;
      month_out_q  <= mon_q + 4'd1;
      day_out_q    <= days_q[4:0] + 5'd1;
      hour_out_q   <= num_q[4:0];
      minute_out_q <= rem_q[5:0];
      second_out_q <= sec_q;
      leap_out_q   <= leap_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign year_o         = year_out_q;
  assign month_number_o = month_out_q;
  assign day_of_month_o = day_out_q;
  assign hour_o         = hour_out_q;
  assign minute_o       = minute_out_q;
  assign second_o       = second_out_q;
  assign leap_year_o    = leap_out_q;

  // accepted transaction starts the day count
  `ASSERT_CLK(a_start_div, (in_valid_i && in_ready_o) |=> (state_q == StDivDay), "transaction did not start the day count")
  // the year walk never runs past the last reachable year
  `ASSERT_NEVER(a_year_bound, (state_q == StYear && year_q > 11'd2038), "year walk out of range")
  // a finished result waits in the done state while the output register is full
  `ASSERT_CLK(a_done_hold, (state_q == StDone && out_valid_q && !out_ready_i) |=> (state_q == StDone), "result dropped while output stalled")
  // fields in range whenever a result is offered
  `ASSERT_CLK(a_out_range, out_valid_o |-> (month_number_o >= 4'd1 && month_number_o <= 4'd12 && hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59 && day_of_month_o != 5'd0), "result field out of range")

endmodule

`default_nettype wire
